FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the keyboard translator; clocked on clk, reset rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/hka_pkg.sv
// ----------------------------------------------------------------------------
// hka_pkg
// Usage codes, lock bits, character tables and shared types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hka_pkg;

    // hid usage codes
    localparam logic [7:0] USAGE_A          = 8'h04;
    localparam logic [7:0] USAGE_Z          = 8'h1D;
    localparam logic [7:0] USAGE_1          = 8'h1E;
    localparam logic [7:0] USAGE_0          = 8'h27;
    localparam logic [7:0] USAGE_ENTER      = 8'h28;
    localparam logic [7:0] USAGE_TAB        = 8'h2B;
    localparam logic [7:0] USAGE_SLASH      = 8'h38;
    localparam logic [7:0] USAGE_CAPSLOCK   = 8'h39;
    localparam logic [7:0] USAGE_SCROLLLOCK = 8'h47;
    localparam logic [7:0] USAGE_NUMLOCK    = 8'h53;

    // left and right shift in the modifier byte
    localparam logic [7:0] SHIFT_MASK = 8'h22;

    // lock led bits
    localparam logic [2:0] LOCK_NUM    = 3'b001;
    localparam logic [2:0] LOCK_CAPS   = 3'b010;
    localparam logic [2:0] LOCK_SCROLL = 3'b100;

    localparam logic [6:0] ASCII_CR = 7'h0D;

    // one translated transaction
    typedef struct packed {
        logic       char_valid;
        logic [6:0] char_code;
        logic [2:0] lock_leds;
        logic       leds_changed;
    } hka_result_t;

    // digit row, index 0 is the '1' key
    function automatic logic [6:0] digit_char(input logic [3:0] idx, input logic shift);
        logic [6:0] ch;
        begin
            case (idx)
                4'd0:    ch = shift ? 7'h21 : 7'h31; // ! 1
                4'd1:    ch = shift ? 7'h40 : 7'h32; // @ 2
                4'd2:    ch = shift ? 7'h23 : 7'h33; // # 3
                4'd3:    ch = shift ? 7'h24 : 7'h34; // $ 4
                4'd4:    ch = shift ? 7'h25 : 7'h35; // % 5
                4'd5:    ch = shift ? 7'h5E : 7'h36; // ^ 6
                4'd6:    ch = shift ? 7'h26 : 7'h37; // & 7
                4'd7:    ch = shift ? 7'h2A : 7'h38; // * 8
                4'd8:    ch = shift ? 7'h28 : 7'h39; // ( 9
                4'd9:    ch = shift ? 7'h29 : 7'h30; // ) 0
                default: ch = 7'h00;
            endcase
            return ch;
        end
    endfunction

    // punctuation keys, index 0 is tab
    function automatic logic [6:0] punct_char(input logic [3:0] idx, input logic shift);
        logic [6:0] ch;
        begin
            case (idx)
                4'd0:    ch = 7'h09;                 // tab
                4'd1:    ch = 7'h20;                 // space
                4'd2:    ch = shift ? 7'h5F : 7'h2D; // _ -
                4'd3:    ch = shift ? 7'h2B : 7'h3D; // + =
                4'd4:    ch = shift ? 7'h7B : 7'h5B; // { [
                4'd5:    ch = shift ? 7'h7D : 7'h5D; // } ]
                4'd6:    ch = shift ? 7'h7C : 7'h5C; // | backslash
                4'd7:    ch = shift ? 7'h7E : 7'h23; // ~ # (non-us hash)
                4'd8:    ch = shift ? 7'h3A : 7'h3B; // : ;
                4'd9:    ch = shift ? 7'h22 : 7'h27; // double and single quote
                4'd10:   ch = shift ? 7'h7E : 7'h60; // ~ grave
                4'd11:   ch = shift ? 7'h3C : 7'h2C; // < ,
                4'd12:   ch = shift ? 7'h3E : 7'h2E; // > .
                4'd13:   ch = shift ? 7'h3F : 7'h2F; // ? /
                default: ch = 7'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/hka_decode.sv
// ----------------------------------------------------------------------------
// hka_decode
// Combinational key translation and lock toggle for one report
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hka_decode
    import hka_pkg::*;
(
    input  wire logic [7:0]  modifier_bits,
    input  wire logic [7:0]  key_usage,
    input  wire logic [2:0]  lock_state,
    output hka_result_t      res,
    output logic      [2:0]  lock_next
);

    logic       shift;
    logic       caps;
    logic [7:0] letter_sum;
    logic [3:0] digit_idx;
    logic [3:0] punct_idx;
    logic [7:0] digit_off;
    logic [7:0] punct_off;
    logic [2:0] toggle;

    assign shift     = (modifier_bits & SHIFT_MASK) != 8'h00;
    assign caps      = (lock_state & LOCK_CAPS) != 3'b000;
    assign digit_off = key_usage - USAGE_1;
    assign punct_off = key_usage - USAGE_TAB;
    assign digit_idx = digit_off[3:0];
    assign punct_idx = punct_off[3:0];

    // 'A' + (key - USAGE_A), plus the case offset for lower case
    assign letter_sum = key_usage + 8'(7'h41) - USAGE_A + ((shift == caps) ? 8'h20 : 8'h00);

    // character select
    always_comb
    begin
        res.char_valid = 1'b0;
        res.char_code  = 7'h00;
        toggle         = 3'b000;
        if (key_usage >= USAGE_A && key_usage <= USAGE_Z)
        begin
            res.char_valid = 1'b1;
            res.char_code  = letter_sum[6:0];
        end
        else if (key_usage >= USAGE_1 && key_usage <= USAGE_0)
        begin
            res.char_valid = 1'b1;
            res.char_code  = digit_char(digit_idx, shift);
        end
        else if (key_usage >= USAGE_TAB && key_usage <= USAGE_SLASH)
        begin
            res.char_valid = 1'b1;
            res.char_code  = punct_char(punct_idx, shift);
        end
        else if (key_usage == USAGE_ENTER)
        begin
            res.char_valid = 1'b1;
            res.char_code  = ASCII_CR;
        end
        else if (key_usage == USAGE_CAPSLOCK)
        begin
            toggle = LOCK_CAPS;
        end
        else if (key_usage == USAGE_NUMLOCK)
        begin
            toggle = LOCK_NUM;
        end
        else if (key_usage == USAGE_SCROLLLOCK)
        begin
            toggle = LOCK_SCROLL;
        end
        // leds after this transaction
        res.lock_leds    = lock_state ^ toggle;
        res.leds_changed = toggle != 3'b000;
    end

    // lock update
    assign lock_next = lock_state ^ toggle;

endmodule

`default_nettype wire

FILE: sv/hka_out_stage.sv
// ----------------------------------------------------------------------------
// hka_out_stage
// Result register holding one translated transaction until taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hka_out_stage
    import hka_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire hka_result_t res,
    input  wire logic        out_stall,
    output logic             out_valid,
    output logic             room,
    output hka_result_t      res_out
);

    logic        valid_reg;
    logic        valid_next;
    hka_result_t res_reg;

    // register frees when empty or being taken
    assign room       = !valid_reg || !out_stall;
    assign valid_next = load ? 1'b1 : (room ? 1'b0 : valid_reg);

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

`default_nettype wire

FILE: sv/hid_key_to_ascii.sv
// ----------------------------------------------------------------------------
// hid_key_to_ascii
// HID boot keyboard report to ASCII translator with lock led tracking
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  input   | in_valid, in_stall  | modifier_bits, key_usage
//  output  | out_valid, out_stall| char_valid, char_code, lock_leds, leds_changed
//
//  One transaction per cycle sustained while out_stall is low; a transaction
//  passes the input register, then is translated into the result register.
//  Lock state updates as a transaction moves into the result register.
//  Reset clears the lock state (all leds off) and both valid flags.
//  A stalled result holds; the input register still takes one transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hid_key_to_ascii
    import hka_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] modifier_bits,
    input  wire logic [7:0] key_usage,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            char_valid,
    output logic [6:0]      char_code,
    output logic [2:0]      lock_leds,
    output logic            leds_changed
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  mods_reg;
    logic [7:0]  key_reg;
    logic [2:0]  lock_state_reg;
    logic [2:0]  lock_state_next;
    logic [2:0]  lock_calc;
    logic        room;
    logic        s1_adv;
    logic        in_acc;
    hka_result_t res;
    hka_result_t res_out;

    // pipeline flow
    assign s1_adv        = s1_valid_reg && room;
    assign in_stall      = s1_valid_reg && !room;
    assign in_acc        = in_valid && !in_stall;
    assign s1_valid_next = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mods_reg <= modifier_bits;
            key_reg  <= key_usage;
        end
    end

    // lock leds
    assign lock_state_next = s1_adv ? lock_calc : lock_state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_state_reg <= 3'b000;
        end
        else
        begin
            lock_state_reg <= lock_state_next;
        end
    end

    hka_decode u_decode (
        .modifier_bits (mods_reg),
        .key_usage     (key_reg),
        .lock_state    (lock_state_reg),
        .res           (res),
        .lock_next     (lock_calc)
    );

    hka_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_adv),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .room      (room),
        .res_out   (res_out)
    );

    assign char_valid   = res_out.char_valid;
    assign char_code    = res_out.char_code;
    assign lock_leds    = res_out.lock_leds;
    assign leds_changed = res_out.leds_changed;

    // checks
    `ASSERT_SAME(a_no_char_zero, out_valid && !char_valid, char_code == 7'h00,
        "char_code nonzero without a character")
    `ASSERT_NEXT(a_lock_change, s1_adv,
        (lock_state_reg != $past(lock_state_reg)) == $past(res.leds_changed),
        "lock state change disagrees with leds_changed")
    `ASSERT_NEXT(a_leds_track, s1_adv, lock_leds == lock_state_reg,
        "reported leds differ from lock state")
    `ASSERT_SAME(a_full_stall, s1_valid_reg && out_valid && out_stall, in_stall,
        "input taken with both stages full")

endmodule

`default_nettype wire

FILE: test/tb_hid_key_to_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hid_key_to_ascii
// Self-checking testbench for the HID boot keyboard to ASCII translator.
// Each accepted report is run through a local model of the letter, digit and
// punctuation tables and of the three lock leds. The expected transaction is
// queued and compared field by field with each result that leaves the block.
// The run covers directed corner keys, lock keys, a stream with no idling, a
// long output hold-off, and random reports with random idling on both channels.
// ----------------------------------------------------------------------------

module tb_hid_key_to_ascii;
    import hka_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] modifier_bits = 8'h00;
    logic [7:0] key_usage = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       char_valid;
    logic [6:0] char_code;
    logic [2:0] lock_leds;
    logic       leds_changed;

    // expected translations, oldest first
    hka_result_t expected_q[$];
    logic [2:0]  lock_model = 3'b000;

    int  error_count = 0;
    int  reports_sent = 0;
    int  results_seen = 0;
    int  chars_seen = 0;
    int  led_updates = 0;
    bit  sender_gaps = 1'b1;
    bit  receiver_gaps = 1'b1;
    int  hold_cycles = 0;

    hid_key_to_ascii DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .modifier_bits(modifier_bits),
        .key_usage    (key_usage),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .char_valid   (char_valid),
        .char_code    (char_code),
        .lock_leds    (lock_leds),
        .leds_changed (leds_changed)
    );

    // clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("%0t: timeout, %0d results still outstanding", $time, expected_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    // translate one report and advance the lock model
    function automatic hka_result_t translate_report(input logic [7:0] mods,
                                                     input logic [7:0] key);
        hka_result_t res;
        logic        shift;
        logic [2:0]  prior;
        string       digit_row;
        string       punct_row;
        int          idx;
        shift = (mods & SHIFT_MASK) != 8'h00;
        prior = lock_model;
        res = '0;
        if (shift)
        begin
            digit_row = "!@#$%^&*()";
            punct_row = "\t _+{}|~:\"~<>?";
        end
        else
        begin
            digit_row = "1234567890";
            punct_row = "\t -=[]\\#;'`,./";
        end
        if (key >= USAGE_A && key <= USAGE_Z)
        begin
            // lower case when shift agrees with caps lock
            res.char_valid = 1'b1;
            res.char_code = 7'(8'h41 + key - USAGE_A);
            if (shift == ((lock_model & LOCK_CAPS) != 3'b000))
                res.char_code = res.char_code + 7'h20;
        end
        else if (key >= USAGE_1 && key <= USAGE_0)
        begin
            idx = int'(key - USAGE_1);
            res.char_valid = 1'b1;
            res.char_code = 7'(digit_row[idx]);
        end
        else if (key >= USAGE_TAB && key <= USAGE_SLASH)
        begin
            idx = int'(key - USAGE_TAB);
            res.char_valid = 1'b1;
            res.char_code = 7'(punct_row[idx]);
        end
        else if (key == USAGE_ENTER)
        begin
            res.char_valid = 1'b1;
            res.char_code = ASCII_CR;
        end
        else if (key == USAGE_CAPSLOCK)
            lock_model = lock_model ^ LOCK_CAPS;
        else if (key == USAGE_NUMLOCK)
            lock_model = lock_model ^ LOCK_NUM;
        else if (key == USAGE_SCROLLLOCK)
            lock_model = lock_model ^ LOCK_SCROLL;
        res.lock_leds = lock_model;
        res.leds_changed = lock_model != prior;
        return res;
    endfunction

    // random key, weighted toward keys that translate
    function automatic logic [7:0] random_key();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return 8'($urandom_range(USAGE_A, USAGE_SLASH));
        else if (pick < 80)
        begin
            case ($urandom_range(2))
                0:       return USAGE_CAPSLOCK;
                1:       return USAGE_NUMLOCK;
                default: return USAGE_SCROLLLOCK;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    // offer one report and wait until the block takes it
    task automatic send_report(input logic [7:0] mods, input logic [7:0] key);
        while (sender_gaps && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        modifier_bits <= mods;
        key_usage     <= key;
        do
            @(posedge clk);
        while (in_stall);
        expected_q.push_back(translate_report(mods, key));
        reports_sent++;
    endtask

    // stop offering and wait for every result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic void compare_field(input string name, input int expected,
                                          input int actual);
        if (expected != actual)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, expected, actual);
            error_count++;
        end
    endfunction

    // result checking and output stall
    always @(posedge clk)
    begin
        hka_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (char_valid)
                chars_seen++;
            if (leds_changed)
                led_updates++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, actual %0b %0h %0h %0b",
                         $time, char_valid, char_code, lock_leds, leds_changed);
                error_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                compare_field("char_valid", want.char_valid, char_valid);
                compare_field("char_code", want.char_code, char_code);
                compare_field("lock_leds", want.lock_leds, lock_leds);
                compare_field("leds_changed", want.leds_changed, leds_changed);
            end
        end
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles--;
        end
        else
            out_stall <= receiver_gaps && ($urandom_range(99) < 24);
    end

    // corner keys: letters, digits, punctuation, enter, unknown codes
    task automatic test_corner_keys();
        send_report(8'h00, USAGE_A);
        send_report(8'h02, USAGE_Z);
        send_report(8'h20, USAGE_A);
        send_report(8'hDD, USAGE_Z);
        send_report(8'hFF, USAGE_1);
        send_report(8'h00, USAGE_0);
        send_report(8'h02, USAGE_TAB);
        send_report(8'h20, USAGE_SLASH);
        // shifted grave and shifted non-us hash both give tilde
        send_report(8'h02, USAGE_SLASH - 8'd3);
        send_report(8'h20, USAGE_TAB + 8'd7);
        send_report(8'h00, USAGE_ENTER);
        send_report(8'h00, 8'h00);
        send_report(8'h00, 8'h01);
        send_report(8'h00, 8'h03);
        send_report(8'hFF, 8'hFF);
        send_report(8'h00, USAGE_ENTER + 8'd1);
        drain_results();
    endtask

    // lock keys toggle their led, caps flips letter case
    task automatic test_lock_keys();
        send_report(8'h00, USAGE_CAPSLOCK);
        send_report(8'h00, USAGE_A);
        send_report(8'h02, USAGE_Z);
        send_report(8'hFF, USAGE_NUMLOCK);
        send_report(8'h00, USAGE_SCROLLLOCK);
        send_report(8'h00, USAGE_SCROLLLOCK);
        send_report(8'h00, USAGE_NUMLOCK);
        send_report(8'h00, USAGE_CAPSLOCK);
        drain_results();
    endtask

    // back to back reports with no idling on either side
    task automatic test_full_rate(input int count);
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        repeat (count) send_report(8'($urandom_range(255)), random_key());
        drain_results();
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    // long output hold-off while reports keep coming
    task automatic test_output_holdoff(input int count);
        sender_gaps = 1'b0;
        hold_cycles = 40;
        repeat (count) send_report(8'($urandom_range(255)), random_key());
        drain_results();
        sender_gaps = 1'b1;
    endtask

    // random reports with idling on both channels
    task automatic test_random_reports(input int count);
        repeat (count) send_report(8'($urandom_range(255)), random_key());
        drain_results();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_keys();
        test_lock_keys();
        test_full_rate(200);
        test_output_holdoff(30);
        test_random_reports(640);

        $display("covered %0d reports: %0d characters, %0d led updates, %0d results checked",
                 reports_sent, chars_seen, led_updates, results_seen);
        $display("phases: corner keys, lock keys, full rate, output hold-off, random idling");
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
